>>> hdl/mte_pkg.sv
// Shared constants and types for the MIDI track event encoder.
`timescale 1ns / 1ps
`default_nettype none
package mte_pkg;

	localparam int TIME_W        = 28;
	localparam int TIME_BITS_DEF = 28;
	localparam int EVT_TIME_W    = TIME_W + 1;
	localparam int CNT_W         = $clog2(TIME_W + 1);
	localparam int VLQ_BITS      = 7;

	localparam logic [1:0] ACT_EVENT   = 2'd0;
	localparam logic [1:0] ACT_PAYLOAD = 2'd1;
	localparam logic [1:0] ACT_END     = 2'd2;

	localparam logic [7:0] ST_NOTE_OFF = 8'h80;
	localparam logic [7:0] ST_NOTE_ON  = 8'h90;
	localparam logic [7:0] ST_CTRL     = 8'hB0;
	localparam logic [7:0] ST_PROGRAM  = 8'hC0;
	localparam logic [7:0] ST_BEND     = 8'hE0;
	localparam logic [7:0] ST_SYSEX    = 8'hF0;
	localparam logic [7:0] ST_META     = 8'hFF;
	localparam logic [7:0] META_EOT    = 8'h2F;

	typedef struct packed {
		logic start;
		logic clear;
	} dctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} dstat_t;

endpackage
`default_nettype wire

>>> hdl/mte_if.sv
// Valid/ready channel interfaces for event items and track bytes.
`timescale 1ns / 1ps
`default_nettype none
interface mte_in_if
	import mte_pkg::*;
;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   action;
	logic signed [EVT_TIME_W-1:0] event_time;
	logic [7:0]                   status;
	logic [4:0]                   channel;
	logic [7:0]                   data_first;
	logic [7:0]                   data_second;
	logic [7:0]                   payload_byte;

	modport source (output valid, action, event_time, status, channel, data_first,
		data_second, payload_byte, input ready);
	modport sink (input valid, action, event_time, status, channel, data_first,
		data_second, payload_byte, output ready);
endinterface

interface mte_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        last;
	logic        bad_item;
	logic [31:0] track_length;

	modport source (output valid, out_byte, last, bad_item, track_length, input ready);
	modport sink (input valid, out_byte, last, bad_item, track_length, output ready);
endinterface
`default_nettype wire

>>> hdl/mte_delta_serial.sv
// Bit-serial tick delta subtractor with clamping, saturation and last-time register.
`timescale 1ns / 1ps
`default_nettype none
module mte_delta_serial
	import mte_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire dctl_t           ctl,
	input  wire [TIME_W-1:0]     t_in,
	output logic [TIME_BITS-1:0] delta,
	output dstat_t               st
);

	logic [TIME_W-1:0]    prev_q;
	logic [TIME_W-1:0]    t_sh_q;
	logic [TIME_W-1:0]    p_sh_q;
	logic [TIME_BITS-1:0] d_sh_q;
	logic [TIME_BITS-1:0] d_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 borrow_q;
	logic                 sat_q;
	logic                 busy_q;
	logic                 done_q;

	logic                 diff;
	logic                 borrow_n;
	logic                 in_range;
	logic [TIME_BITS-1:0] d_next;
	logic                 sat_next;

	always_comb begin
		diff     = t_sh_q[0] ^ p_sh_q[0] ^ borrow_q;
		borrow_n = (~t_sh_q[0] & p_sh_q[0]) | (~(t_sh_q[0] ^ p_sh_q[0]) & borrow_q);
		in_range = cnt_q < CNT_W'(TIME_BITS);
		d_next   = in_range ? {diff, d_sh_q[TIME_BITS-1:1]} : d_sh_q;
		sat_next = sat_q | (~in_range & diff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.clear) begin
				prev_q <= '0;
			end else if (ctl.start) begin
				prev_q <= t_in;
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CNT_W'(TIME_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			t_sh_q   <= t_in;
			p_sh_q   <= prev_q;
			cnt_q    <= '0;
			borrow_q <= 1'b0;
			sat_q    <= 1'b0;
		end else if (busy_q) begin
			t_sh_q   <= t_sh_q >> 1;
			p_sh_q   <= p_sh_q >> 1;
			cnt_q    <= cnt_q + CNT_W'(1);
			borrow_q <= borrow_n;
			sat_q    <= sat_next;
			d_sh_q   <= d_next;
			if (cnt_q == CNT_W'(TIME_W - 1)) begin
				if (borrow_n) begin
					d_q <= '0;
				end else if (sat_next) begin
					d_q <= '1;
				end else begin
					d_q <= d_next;
				end
			end
		end
	end

	assign delta   = d_q;
	assign st.busy = busy_q;
	assign st.done = done_q;

endmodule
`default_nettype wire

>>> hdl/midi_track_event_encoder.sv
// Top level: event stream to Standard MIDI File track bytes, one byte per transfer.
// An event with non-negative time is taken in, runs through the bit-serial delta subtractor, is
// handed over, and then gives its track bytes (one to seven), one per cycle while the output is
// not stalled. A payload byte or an unexpected payload byte gives one output byte, end of track
// four, and an event with negative time none. The last byte of an item waits in the output
// register while the next item is taken.
// The delta is clamped to zero when time runs backward and saturates at 2^TIME_BITS - 1.
`timescale 1ns / 1ps
`default_nettype none
module midi_track_event_encoder
	import mte_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire    clk,
	input  wire    arst_n,
	mte_in_if.sink    in_ch,
	mte_out_if.source out_ch
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DELTA,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		K_EVENT,
		K_PAYLOAD,
		K_BADPAY,
		K_END
	} kind_t;

	state_t      state_q;
	kind_t       kind_q;
	logic [2:0]  idx_q;
	logic [2:0]  cnt_q;
	logic [2:0]  grp_q;
	logic [7:0]  rem_q;
	logic [31:0] bytes_q;
	logic [7:0]  status_q;
	logic [3:0]  chm1_q;
	logic [7:0]  d1_q;
	logic [7:0]  d2_q;
	logic [7:0]  pb_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic        out_bad_q;
	logic [31:0] out_len_q;

	dctl_t                dctl;
	dstat_t               dst;
	logic [TIME_BITS-1:0] delta;
	logic [TIME_W-1:0]    dz;
	logic [2:0]           groups;
	logic [2:0]           ev_n;
	logic                 known;
	logic                 load;
	logic                 accept;
	logic [2:0]           e_idx;
	logic [1:0]           g_idx;
	logic [7:0]           cur_byte;
	logic                 cur_bad;

	mte_delta_serial #(
		.TIME_BITS(TIME_BITS)
	) u_delta (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (dctl),
		.t_in  (in_ch.event_time[TIME_W-1:0]),
		.delta (delta),
		.st    (dst)
	);

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign load        = (state_q == S_EMIT) && (!out_valid_q || out_ch.ready);

	always_comb begin
		dctl.start = accept && in_ch.action == ACT_EVENT && !in_ch.event_time[TIME_W];
		dctl.clear = load && kind_q == K_END && idx_q == cnt_q - 3'd1;
	end

	always_comb begin
		dz = TIME_W'(delta);
		if (|dz[27:21]) begin
			groups = 3'd4;
		end else if (|dz[20:14]) begin
			groups = 3'd3;
		end else if (|dz[13:7]) begin
			groups = 3'd2;
		end else begin
			groups = 3'd1;
		end
		known = 1'b1;
		unique case (status_q)
			ST_NOTE_OFF, ST_NOTE_ON, ST_CTRL, ST_BEND, ST_META: ev_n = 3'd3;
			ST_PROGRAM, ST_SYSEX: ev_n = 3'd2;
			default: begin
				ev_n  = 3'd0;
				known = 1'b0;
			end
		endcase
	end

	always_comb begin
		e_idx    = idx_q - grp_q;
		g_idx    = 2'(grp_q - idx_q - 3'd1);
		cur_byte = 8'h00;
		cur_bad  = 1'b0;
		unique case (kind_q)
			K_EVENT: begin
				if (idx_q < grp_q) begin
					cur_bad = !known;
					unique case (g_idx)
						2'd0: cur_byte = {1'b0, dz[0 +: VLQ_BITS]};
						2'd1: cur_byte = {1'b1, dz[VLQ_BITS +: VLQ_BITS]};
						2'd2: cur_byte = {1'b1, dz[2 * VLQ_BITS +: VLQ_BITS]};
						default: cur_byte = {1'b1, dz[3 * VLQ_BITS +: VLQ_BITS]};
					endcase
				end else begin
					priority case (e_idx)
						3'd0: begin
							if (status_q == ST_SYSEX || status_q == ST_META) begin
								cur_byte = status_q;
							end else begin
								cur_byte = status_q | {4'h0, chm1_q};
							end
						end
						3'd1: cur_byte = d1_q;
						default: cur_byte = d2_q;
					endcase
				end
			end
			K_PAYLOAD: cur_byte = pb_q;
			K_BADPAY: cur_bad = 1'b1;
			default: begin
				unique case (idx_q[1:0])
					2'd1: cur_byte = ST_META;
					2'd2: cur_byte = META_EOT;
					default: cur_byte = 8'h00;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rem_q       <= '0;
			bytes_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						grp_q <= '0;
						unique case (in_ch.action)
							ACT_EVENT: begin
								rem_q <= '0;
								if (!in_ch.event_time[TIME_W]) begin
									kind_q   <= K_EVENT;
									status_q <= in_ch.status;
									chm1_q   <= 4'(in_ch.channel - 5'd1);
									d1_q     <= in_ch.data_first;
									d2_q     <= in_ch.data_second;
									if (in_ch.status == ST_SYSEX) begin
										rem_q <= in_ch.data_first;
									end else if (in_ch.status == ST_META) begin
										rem_q <= in_ch.data_second;
									end
									state_q <= S_DELTA;
								end
							end
							ACT_PAYLOAD: begin
								pb_q  <= in_ch.payload_byte;
								cnt_q <= 3'd1;
								if (rem_q == 8'd0) begin
									kind_q <= K_BADPAY;
								end else begin
									kind_q <= K_PAYLOAD;
									rem_q  <= rem_q - 8'd1;
								end
								state_q <= S_EMIT;
							end
							ACT_END: begin
								kind_q  <= K_END;
								cnt_q   <= 3'd4;
								state_q <= S_EMIT;
							end
							default: ;
						endcase
					end
				end
				S_DELTA: begin
					if (dst.done) begin
						grp_q   <= groups;
						cnt_q   <= groups + ev_n;
						state_q <= S_EMIT;
					end
				end
				default: begin
					if (load) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= cur_byte;
						out_bad_q   <= cur_bad;
						out_last_q  <= (idx_q == cnt_q - 3'd1);
						idx_q       <= idx_q + 3'd1;
						if (kind_q == K_BADPAY) begin
							out_len_q <= bytes_q;
						end else begin
							out_len_q <= bytes_q + 32'd1;
							bytes_q   <= bytes_q + 32'd1;
						end
						if (idx_q == cnt_q - 3'd1) begin
							state_q <= S_IDLE;
							if (kind_q == K_END) begin
								bytes_q <= '0;
								rem_q   <= '0;
							end
						end
					end
				end
			endcase
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.out_byte     = out_byte_q;
	assign out_ch.last         = out_last_q;
	assign out_ch.bad_item     = out_bad_q;
	assign out_ch.track_length = out_len_q;

	a_ready_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !dst.busy)
		else $error("input taken while the delta subtractor runs");

	a_done_in_delta: assert property (@(posedge clk) disable iff (!arst_n)
		dst.done |-> state_q == S_DELTA)
		else $error("delta finished outside its wait state");

	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> idx_q < cnt_q)
		else $error("byte index ran past the byte count");

endmodule
`default_nettype wire
